// ----- hw/rtl/gcp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcp_pkg: shared types and constants of the gain, clip and PCM encoder
// Field widths, register indexes, depth and container codes, and the queue
// entry that passes a quantized word from the front end to the serializer.
// ----------------------------------------------------------------------------
package gcp_pkg;

  localparam int SAMPLE_W = 32;
  localparam int GAIN_W   = 24;
  localparam int WORD_W   = 32;
  localparam int BYTE_W   = 8;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_GAIN        = 2'd0,
    REG_CONTAINER   = 2'd1,
    REG_DEPTH_CODE  = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    DEPTH_8  = 2'd0,
    DEPTH_16 = 2'd1,
    DEPTH_24 = 2'd2,
    DEPTH_32 = 2'd3
  } depth_t;

  typedef enum logic {
    CONT_WAV  = 1'b0,
    CONT_AIFF = 1'b1
  } container_t;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

  // Full-scale factors are all 2^n - 1, so m*K is (m << n) - m.
  localparam int SHIFT_WAV8  = 8;
  localparam int SHIFT_AIFF8 = 7;
  localparam int SHIFT_16    = 15;
  localparam int SHIFT_24    = 23;
  localparam int SHIFT_32    = 31;
  localparam int MAX_SHIFT   = 31;

  // Queue between front end and serializer.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    depth_t            depth;
    container_t        cont;
  } entry_t;

endpackage

// ----- hw/rtl/gcp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcp_front: gain, clip and quantize pipeline
// Three stages: gain multiply, clip to plus or minus one and take the
// magnitude, then scale to the PCM depth and restore the sign.
// ----------------------------------------------------------------------------
module gcp_front #(
  parameter int SAMPLE_FRAC_BITS = 30,
  parameter int GAIN_FRAC_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [gcp_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [gcp_pkg::GAIN_W-1:0]         gain_coef,
  input  gcp_pkg::container_t                container,
  input  gcp_pkg::depth_t                    depth_code,
  output logic                               ent_valid,
  input  logic                               ent_ready,
  output gcp_pkg::entry_t                    ent
);

  localparam int F  = SAMPLE_FRAC_BITS + GAIN_FRAC_BITS;
  localparam int PW = gcp_pkg::SAMPLE_W + gcp_pkg::GAIN_W + 1;
  localparam int MW = F + 2;
  localparam int SW = MW + gcp_pkg::MAX_SHIFT;
  localparam logic signed [PW-1:0] ONE = PW'(1) << F;

  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  logic signed [PW-1:0] prod;
  gcp_pkg::depth_t      d1, d2, d3;
  gcp_pkg::container_t  c1, c2, c3;

  logic [MW-1:0] mag;
  logic          neg;
  logic [gcp_pkg::WORD_W-1:0] word;

  logic signed [PW-1:0] s_ext, g_ext, mul_c, clip_c, mag_c;
  logic                 wav8_c;
  logic [SW-1:0]        m_ext, shl_c, diff_c, q_c;
  logic [gcp_pkg::WORD_W-1:0] q32_c;

  assign adv3     = !v3 || ent_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  // Stage 1: exact product of the signed sample and the unsigned gain.
  assign s_ext = PW'(sample_in);
  assign g_ext = $signed({{(PW - gcp_pkg::GAIN_W){1'b0}}, gain_coef});
  assign mul_c = s_ext * g_ext;

  // Stage 2: clip and fold to a magnitude (offset for WAV 8-bit).
  assign wav8_c = (d1 == gcp_pkg::DEPTH_8) && (c1 == gcp_pkg::CONT_WAV);
  always_comb begin
    if (prod > ONE) begin
      clip_c = ONE;
    end else if (prod < -ONE) begin
      clip_c = -ONE;
    end else begin
      clip_c = prod;
    end
    if (wav8_c) begin
      mag_c = clip_c + ONE;
    end else if (clip_c < 0) begin
      mag_c = -clip_c;
    end else begin
      mag_c = clip_c;
    end
  end

  // Stage 3: floor(m * (2^n - 1) / 2^sh).
  assign m_ext = SW'(mag);
  always_comb begin
    case (d2)
      gcp_pkg::DEPTH_8: begin
        if (c2 == gcp_pkg::CONT_WAV) begin
          shl_c = m_ext << gcp_pkg::SHIFT_WAV8;
        end else begin
          shl_c = m_ext << gcp_pkg::SHIFT_AIFF8;
        end
      end
      gcp_pkg::DEPTH_16: shl_c = m_ext << gcp_pkg::SHIFT_16;
      gcp_pkg::DEPTH_24: shl_c = m_ext << gcp_pkg::SHIFT_24;
      default:           shl_c = m_ext << gcp_pkg::SHIFT_32;
    endcase
    diff_c = shl_c - m_ext;
    if ((d2 == gcp_pkg::DEPTH_8) && (c2 == gcp_pkg::CONT_WAV)) begin
      q_c = diff_c >> (F + 1);
    end else begin
      q_c = diff_c >> F;
    end
    q32_c = q_c[gcp_pkg::WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
        if (in_valid) begin
          prod <= mul_c;
          d1   <= depth_code;
          c1   <= container;
        end
      end
      if (adv2) begin
        v2 <= v1;
        if (v1) begin
          mag <= mag_c[MW-1:0];
          neg <= !wav8_c && (clip_c < 0);
          d2  <= d1;
          c2  <= c1;
        end
      end
      if (adv3) begin
        v3 <= v2;
        if (v2) begin
          word <= neg ? (gcp_pkg::WORD_W'(0) - q32_c) : q32_c;
          d3   <= d2;
          c3   <= c2;
        end
      end
    end
  end

  assign ent_valid  = v3;
  assign ent.word   = word;
  assign ent.depth  = d3;
  assign ent.cont   = c3;

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (v3 && !ent_ready) |=> v3)
    else $error("front output stage dropped a stalled item");

endmodule

// ----- hw/rtl/gcp_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcp_fifo: two-entry queue between front end and serializer
// Lets the quantizer run ahead while the serializer is still sending bytes.
// ----------------------------------------------------------------------------
module gcp_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  gcp_pkg::entry_t wr_ent,
  output logic            rd_valid,
  input  logic            rd_ready,
  output gcp_pkg::entry_t rd_ent
);

  gcp_pkg::entry_t mem [gcp_pkg::QDEPTH];
  logic [gcp_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [gcp_pkg::QCNT_W-1:0] count;
  logic push, pop;

  assign wr_ready = (count != gcp_pkg::QCNT_W'(gcp_pkg::QDEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_ent   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    ((count == '0) || (count == gcp_pkg::QCNT_W'(gcp_pkg::QDEPTH))) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with the fill count");

endmodule

// ----- hw/rtl/gcp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcp_back: byte serializer
// Sends the bytes of each quantized word in container order, one a cycle
// while the receiver takes them, through an output register; marks the final byte.
// ----------------------------------------------------------------------------
module gcp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  gcp_pkg::entry_t             q_ent,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gcp_pkg::BYTE_W-1:0]  out_byte,
  output logic                        last_byte
);

  gcp_pkg::entry_t cur;
  logic            cur_valid;
  logic [1:0]      idx;

  logic       emit, last_c, load;
  logic [1:0] pos;
  logic [gcp_pkg::BYTE_W-1:0] byte_c;

  assign emit    = cur_valid && (!out_valid || out_ready);
  assign last_c  = (idx == cur.depth);
  assign q_ready = !cur_valid || (emit && last_c);
  assign load    = q_valid && q_ready;
  assign pos     = (cur.cont == gcp_pkg::CONT_AIFF) ? (cur.depth - idx) : idx;
  assign byte_c  = cur.word[{pos, 3'b000} +: gcp_pkg::BYTE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        out_byte  <= byte_c;
        last_byte <= last_c;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        idx <= '0;
      end else if (emit) begin
        idx <= idx + 1'b1;
      end
      if (load) begin
        cur       <= q_ent;
        cur_valid <= 1'b1;
      end else if (emit && last_c) begin
        cur_valid <= 1'b0;
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (idx <= cur.depth))
    else $error("byte index ran past the sample depth");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (emit && last_c && !q_valid) |=> !cur_valid)
    else $error("serializer kept a finished word");

endmodule

// ----- hw/rtl/gain_clip_pcm_sample_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_clip_pcm_sample_encoder: gain, clip and PCM byte encoder
// Scales signed fixed-point samples, clips them to full scale, quantizes them
// to 8, 16, 24 or 32 bits and sends them as bytes for WAV or AIFF.
// ----------------------------------------------------------------------------
// Each item on the input is one signed sample with SAMPLE_FRAC_BITS fraction
// bits. It is multiplied by the unsigned gain register, clipped to plus or
// minus one, truncated toward zero to the selected depth and sent as one to
// four byte items, little-endian for WAV and big-endian for AIFF, with
// last_byte set on the final byte. WAV 8-bit output is offset unsigned, AIFF
// 8-bit output is signed. The serializer sends one byte a cycle while the
// output is ready, so a sample makes depth_code + 1 byte items. A new sample
// can be taken every cycle while the three-stage quantizer and the two-entry
// queue behind it have room; the byte serializer sets the sustained rate. An
// accepted sample passes the three quantizer stages, the queue and the
// serializer's word and output registers on the way to its first byte.
// Registers are written through the configuration port, which is always
// ready; they should be changed only while no sample is in flight, as each
// sample captures the container and depth as it enters.
// ----------------------------------------------------------------------------
module gain_clip_pcm_sample_encoder #(
  parameter int SAMPLE_FRAC_BITS = 30,
  parameter int GAIN_FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample input
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [gcp_pkg::SAMPLE_W-1:0] sample_in,
  // byte output
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gcp_pkg::BYTE_W-1:0]          out_byte,
  output logic                                last_byte,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [gcp_pkg::GAIN_W-1:0]          cfg_data
);

  logic [gcp_pkg::GAIN_W-1:0] gain_coef;
  gcp_pkg::container_t        container;
  gcp_pkg::depth_t            depth_code;

  logic            f_valid, f_ready;
  gcp_pkg::entry_t f_ent;
  logic            q_valid, q_ready;
  gcp_pkg::entry_t q_ent;

  // The register file never stalls a write; an index past the last register
  // is accepted and dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_coef   <= gcp_pkg::GAIN_RESET;
      container   <= gcp_pkg::CONT_WAV;
      depth_code  <= gcp_pkg::DEPTH_16;
    end else if (cfg_valid && cfg_ready) begin
      case (gcp_pkg::reg_index_t'(cfg_index))
        gcp_pkg::REG_GAIN:        gain_coef   <= cfg_data;
        gcp_pkg::REG_CONTAINER:   container   <= gcp_pkg::container_t'(cfg_data[0]);
        gcp_pkg::REG_DEPTH_CODE:  depth_code  <= gcp_pkg::depth_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // Front end: multiply, clip and quantize, one sample per cycle while the queue has room.
  gcp_front #(
    .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS),
    .GAIN_FRAC_BITS   (GAIN_FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_in   (sample_in),
    .gain_coef   (gain_coef),
    .container   (container),
    .depth_code  (depth_code),
    .ent_valid   (f_valid),
    .ent_ready   (f_ready),
    .ent         (f_ent)
  );

  // Queue so the quantizer can run ahead of a multi-byte sample.
  gcp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_ent   (f_ent),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_ent   (q_ent)
  );

  // Back end: one byte item per cycle while the receiver takes them, through the output register.
  gcp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_ent     (q_ent),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

endmodule

// ----- sim/gain_clip_pcm_sample_encoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_clip_pcm_sample_encoder_tb: self-checking bench for the PCM encoder
// Sends samples through gain, clip and quantization under all container and
// depth settings, predicts each byte item and compares it with the output.
// ----------------------------------------------------------------------------
module gain_clip_pcm_sample_encoder_tb;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 3;
  localparam int TAIL_CYCLES    = 20;
  localparam int TIMEOUT_CYCLES = 200_000;
  localparam int MAX_REPORTS    = 10;
  localparam int RAND_PHASES    = 3;
  localparam int RAND_PER_PHASE = 44;

  localparam int SAMPLE_FRAC    = 30;
  localparam int GAIN_FRAC      = 16;
  // Fraction bits of the exact product of sample and gain.
  localparam int PROD_FRAC      = SAMPLE_FRAC + GAIN_FRAC;

  // Full-scale factors of each output format.
  localparam logic [31:0] WAV8_SCALE  = 32'd255;
  localparam logic [31:0] AIFF8_SCALE = 32'd127;
  localparam logic [31:0] PCM16_SCALE = 32'd32767;
  localparam logic [31:0] PCM24_SCALE = 32'd8388607;
  localparam logic [31:0] PCM32_SCALE = 32'd2147483647;

  // Sample values of interest in Q1.30.
  localparam logic [31:0] PLUS_ONE  = 32'h4000_0000;
  localparam logic [31:0] MINUS_ONE = 32'hC000_0000;
  localparam logic [31:0] MOST_POS  = 32'h7FFF_FFFF;
  localparam logic [31:0] MOST_NEG  = 32'h8000_0000;

  // What the driver does with the entry at the head of its feed.
  typedef enum logic [1:0] {
    ACT_SAMPLE,
    ACT_WRITE,
    ACT_DRAIN,
    ACT_IDLE_MIX
  } action_t;

  typedef struct {
    action_t             act;
    logic [31:0]         sample;
    gcp_pkg::reg_index_t idx;
    logic [23:0]         data;
    int                  tx_idle;
    int                  rx_idle;
  } feed_entry_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pcm_byte_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] sample_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_byte;
  logic               last_byte;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;

  // Items still to be offered, and bytes predicted but not yet seen.
  feed_entry_t stim_feed[$];
  pcm_byte_t   pcm_bytes_due[$];

  // The bench's own copy of the registers, updated as each write is taken.
  logic [23:0]         gain_shadow      = gcp_pkg::GAIN_RESET;
  gcp_pkg::container_t container_shadow = gcp_pkg::CONT_WAV;
  gcp_pkg::depth_t     depth_shadow     = gcp_pkg::DEPTH_16;

  int tx_idle_pct = 21;
  int rx_idle_pct = 74;
  int fail_count  = 0;

  gain_clip_pcm_sample_encoder #(
    .SAMPLE_FRAC_BITS(SAMPLE_FRAC),
    .GAIN_FRAC_BITS  (GAIN_FRAC)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last_byte (last_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  function automatic void queue_sample(input logic [31:0] smp);
    feed_entry_t entry;
    entry = '{ACT_SAMPLE, smp, gcp_pkg::REG_UNUSED, '0, 0, 0};
    stim_feed.push_back(entry);
  endfunction

  function automatic void queue_write(input gcp_pkg::reg_index_t idx,
                                      input logic [23:0] data);
    feed_entry_t entry;
    entry = '{ACT_WRITE, '0, idx, data, 0, 0};
    stim_feed.push_back(entry);
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  // Works out the bytes that one sample produces under the current register
  // copy. The product is kept exact in 64 bits, clipped to plus or minus one,
  // and scaled with a wide multiply so that the truncation is exact too.
  function automatic void encode_sample(input logic signed [31:0] smp);
    longint      prod;
    longint      full;
    logic [95:0] wide;
    logic [31:0] word;
    logic [31:0] scale;
    int          nbytes;
    int          pos;
    pcm_byte_t   b;
    full = longint'(1) << PROD_FRAC;
    prod = longint'(smp) * longint'(gain_shadow);
    if (prod > full) prod = full;
    if (prod < -full) prod = -full;
    if (depth_shadow == gcp_pkg::DEPTH_8 && container_shadow == gcp_pkg::CONT_WAV) begin
      // Offset unsigned: (s + 1) * 127.5, truncated, gives 0 to 255.
      wide = 96'(prod + full);
      wide = wide * WAV8_SCALE;
      word = 32'(wide >> (PROD_FRAC + 1));
    end else begin
      case (depth_shadow)
        gcp_pkg::DEPTH_8: begin
          scale = AIFF8_SCALE;
        end
        gcp_pkg::DEPTH_16: begin
          scale = PCM16_SCALE;
        end
        gcp_pkg::DEPTH_24: begin
          scale = PCM24_SCALE;
        end
        default: begin
          scale = PCM32_SCALE;
        end
      endcase
      // Truncation toward zero: scale the magnitude, then restore the sign.
      wide = 96'((prod < 0) ? -prod : prod);
      wide = wide * scale;
      word = 32'(wide >> PROD_FRAC);
      if (prod < 0) word = -word;
    end
    nbytes = int'(depth_shadow) + 1;
    for (int i = 0; i < nbytes; i++) begin
      pos = (container_shadow == gcp_pkg::CONT_AIFF) ? nbytes - 1 - i : i;
      b.data = word[8*pos +: 8];
      b.last = (i == nbytes - 1);
      pcm_bytes_due.push_back(b);
    end
  endfunction

  // Driver. Taken items are retired first, then the head of the feed decides
  // what is offered next. Valid and its payload are held until the handshake;
  // register writes and drain points wait until every predicted byte has come
  // back, so no sample is in flight when a register changes.
  always @(posedge clk) begin
    logic raise_in;
    logic raise_cfg;
    raise_in  = 1'b0;
    raise_cfg = 1'b0;
    if (rst) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        encode_sample(sample_in);
        void'(stim_feed.pop_front());
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gcp_pkg::REG_GAIN: begin
            gain_shadow = cfg_data;
          end
          gcp_pkg::REG_CONTAINER: begin
            container_shadow = gcp_pkg::container_t'(cfg_data[0]);
          end
          gcp_pkg::REG_DEPTH_CODE: begin
            depth_shadow = gcp_pkg::depth_t'(cfg_data[1:0]);
          end
          default: begin
            // Writes beyond the last register leave everything as it was.
          end
        endcase
        void'(stim_feed.pop_front());
      end
      if (in_valid && !in_ready) begin
        raise_in = 1'b1;
      end else if (cfg_valid && !cfg_ready) begin
        raise_cfg = 1'b1;
      end else if (stim_feed.size() != 0) begin
        case (stim_feed[0].act)
          ACT_SAMPLE: begin
            if ($urandom_range(99) >= tx_idle_pct) begin
              raise_in = 1'b1;
              sample_in <= stim_feed[0].sample;
            end
          end
          ACT_WRITE: begin
            if (pcm_bytes_due.size() == 0) begin
              raise_cfg = 1'b1;
              cfg_index <= stim_feed[0].idx;
              cfg_data  <= stim_feed[0].data;
            end
          end
          ACT_DRAIN: begin
            if (pcm_bytes_due.size() == 0) void'(stim_feed.pop_front());
          end
          default: begin
            tx_idle_pct = stim_feed[0].tx_idle;
            rx_idle_pct = stim_feed[0].rx_idle;
            void'(stim_feed.pop_front());
          end
        endcase
      end
      in_valid  <= raise_in;
      cfg_valid <= raise_cfg;
    end
  end

  // Monitor. Every byte item taken is matched against the oldest prediction;
  // ready is redrawn each cycle from the current receiver idling mix.
  always @(posedge clk) begin
    pcm_byte_t due;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pcm_bytes_due.size() == 0) begin
          note_failure($sformatf("unexpected byte item: byte %02h last %0b",
                                 out_byte, last_byte));
        end else begin
          due = pcm_bytes_due.pop_front();
          if (out_byte !== due.data || last_byte !== due.last) begin
            note_failure($sformatf("byte mismatch: expected %02h last %0b, got %02h last %0b",
                                   due.data, due.last, out_byte, last_byte));
          end
        end
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Stimulus, then the wait for the last byte and the verdict.
  initial begin
    feed_entry_t entry;
    int          tx_mix[RAND_PHASES];
    int          rx_mix[RAND_PHASES];
    int          pick;
    logic [31:0] smp;
    logic [23:0] gain;
    tx_mix = '{21, 74, 0};
    rx_mix = '{74, 21, 0};

    // Directed part. Reset settings first: gain 1.0, WAV, 16 bits, with both
    // full-scale values and the field extremes, which clip to full scale.
    queue_sample(PLUS_ONE);
    queue_sample(MINUS_ONE);
    queue_sample(MOST_POS);
    queue_sample(MOST_NEG);
    queue_sample(32'h0000_0000);
    // Full scale at 32 bits saturates to 2147483647 and its negative.
    queue_write(gcp_pkg::REG_DEPTH_CODE, {22'd0, gcp_pkg::DEPTH_32});
    queue_sample(PLUS_ONE);
    queue_sample(MINUS_ONE);
    queue_sample(32'h0000_0001);
    // Container set with all data bits high; only the lowest bit counts.
    queue_write(gcp_pkg::REG_CONTAINER, 24'hFF_FFFF);
    queue_sample(PLUS_ONE);
    queue_sample(MINUS_ONE);
    // Signed 8-bit AIFF, with the depth code hidden among masked bits.
    queue_write(gcp_pkg::REG_DEPTH_CODE, 24'hFF_FFFC);
    queue_sample(PLUS_ONE);
    queue_sample(MINUS_ONE);
    queue_sample(32'hFFFF_FFFF);
    // Offset unsigned 8-bit WAV.
    queue_write(gcp_pkg::REG_CONTAINER, 24'hFF_FFFE);
    queue_sample(PLUS_ONE);
    queue_sample(MINUS_ONE);
    queue_sample(32'h0000_0000);
    // A write past the last register must change nothing; then the largest
    // gain, where even tiny samples grow and most clip.
    queue_write(gcp_pkg::REG_UNUSED, 24'h12_3456);
    queue_write(gcp_pkg::REG_GAIN, 24'hFF_FFFF);
    queue_write(gcp_pkg::REG_DEPTH_CODE, {22'd0, gcp_pkg::DEPTH_24});
    queue_sample(32'h0000_0001);
    queue_sample(32'hFFFF_FFFF);
    queue_sample(32'h0010_0000);
    // Zero gain silences even the largest sample.
    queue_write(gcp_pkg::REG_GAIN, 24'h00_0000);
    queue_sample(MOST_POS);

    // Random part, in three idling mixes. Registers are redrawn every ten
    // items, and halfway through each phase the sender holds off until the
    // output has caught up.
    for (int p = 0; p < RAND_PHASES; p++) begin
      entry = '{ACT_IDLE_MIX, '0, gcp_pkg::REG_UNUSED, '0, tx_mix[p], rx_mix[p]};
      stim_feed.push_back(entry);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (n % 10 == 0) begin
          case ($urandom_range(4))
            0: begin
              gain = gcp_pkg::GAIN_RESET;
            end
            1: begin
              gain = 24'($urandom_range(24'h02_0000));
            end
            2: begin
              gain = 24'($urandom);
            end
            3: begin
              gain = ($urandom_range(1) == 0) ? 24'h00_0000 : 24'hFF_FFFF;
            end
            default: begin
              gain = 24'($urandom_range(24'h01_1000, 24'h00_F000));
            end
          endcase
          queue_write(gcp_pkg::REG_GAIN, gain);
          queue_write(gcp_pkg::REG_CONTAINER, 24'($urandom));
          queue_write(gcp_pkg::REG_DEPTH_CODE, 24'($urandom));
          if ($urandom_range(3) == 0) queue_write(gcp_pkg::REG_UNUSED, 24'($urandom));
        end
        if (n == RAND_PER_PHASE / 2) begin
          entry = '{ACT_DRAIN, '0, gcp_pkg::REG_UNUSED, '0, 0, 0};
          stim_feed.push_back(entry);
        end
        pick = $urandom_range(99);
        if (pick < 40) begin
          smp = $urandom;
        end else if (pick < 70) begin
          // Within plus or minus one, where gains near unity do not clip.
          smp = $urandom_range(32'h8000_0000) - 32'h4000_0000;
        end else if (pick < 85) begin
          smp = $urandom_range(32'h0002_0000) - 32'h0001_0000;
        end else begin
          case ($urandom_range(5))
            0: begin
              smp = PLUS_ONE;
            end
            1: begin
              smp = MINUS_ONE;
            end
            2: begin
              smp = MOST_POS;
            end
            3: begin
              smp = MOST_NEG;
            end
            4: begin
              smp = 32'h0000_0000;
            end
            default: begin
              smp = 32'hFFFF_FFFF;
            end
          endcase
        end
        queue_sample(smp);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (stim_feed.size() != 0 || pcm_bytes_due.size() != 0) @(posedge clk);
    // Leave room for any stray byte to show up after the last expected one.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("gain_clip_pcm_sample_encoder test passed");
    end else begin
      $display("gain_clip_pcm_sample_encoder test failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("gain_clip_pcm_sample_encoder test failed");
    $finish;
  end

endmodule
